@@ rtl/rmrst_pkg.sv @@
// Shared types and constants for the range-multiply range-sum tree.
`timescale 1ns / 1ps
package rmrst_pkg;

  localparam int MAX_LEAVES = 1024;
  localparam int FRAC_BITS  = 32;
  localparam int LEAF_W     = 11;
  localparam int TAG_W      = FRAC_BITS + 1;
  localparam int SUM_W      = LEAF_W + FRAC_BITS;
  localparam int ACC_W      = SUM_W + 1;
  localparam int OUT_SUM_W  = 42;
  localparam int NODE_AW    = 12;
  localparam int NODE_DEPTH = 1 << NODE_AW;
  localparam int NODE_W     = TAG_W + SUM_W;
  localparam int STK_W      = 4;
  localparam int STK_DEPTH  = 1 << STK_W;

  localparam logic [TAG_W-1:0] ONE_Q = TAG_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    REQ_INIT = 2'd0,
    REQ_MUL  = 2'd1,
    REQ_QRY  = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    OP_BUILD = 2'd0,
    OP_SCALE = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [SUM_W-1:0] sum;
  } node_t;

  typedef struct packed {
    logic              start;
    op_e               op;
    logic [LEAF_W-1:0] lo;
    logic [LEAF_W-1:0] hi;
    logic [LEAF_W-1:0] n;
    logic [TAG_W-1:0]  factor;
  } seq_cmd_t;

  typedef struct packed {
    logic             ready;
    logic             done;
    logic [ACC_W-1:0] sum;
  } seq_sts_t;

endpackage

@@ rtl/rmrst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rmrst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/rmrst_mul.sv @@
// Fixed-point scaling unit: (a * b) >> 32 with b at most 1.0, on one 32x32 multiplier.
`timescale 1ns / 1ps
module rmrst_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rmrst_pkg::SUM_W-1:0] a_i,
  input  logic [rmrst_pkg::TAG_W-1:0] b_i,
  output logic                       done_o,
  output logic [rmrst_pkg::SUM_W-1:0] res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LO,
    PH_HI,
    PH_SUM
  } ph_e;

  localparam int FB = rmrst_pkg::FRAC_BITS;

  ph_e                          ph_q;
  logic [rmrst_pkg::SUM_W-1:0]  a_q;
  logic [rmrst_pkg::TAG_W-1:0]  b_q;
  logic [2*FB-1:0]              prod_q;
  logic [FB-1:0]                lo_q;
  logic                         done_q;
  logic [rmrst_pkg::SUM_W-1:0]  res_q;
  logic [FB-1:0]                mul_a;
  logic [2*FB-1:0]              mul_p;

  // low word of a first, then the high bits
  assign mul_a = (ph_q == PH_LO) ? a_q[FB-1:0] : FB'(a_q[rmrst_pkg::SUM_W-1:FB]);
  assign mul_p = mul_a * b_q[FB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (ph_q)
        PH_IDLE: begin
          if (start_i) begin
            a_q  <= a_i;
            b_q  <= b_i;
            ph_q <= PH_LO;
          end
        end
        PH_LO: begin
          prod_q <= mul_p;
          ph_q   <= PH_HI;
        end
        PH_HI: begin
          lo_q   <= prod_q[2*FB-1:FB];
          prod_q <= mul_p;
          ph_q   <= PH_SUM;
        end
        PH_SUM: begin
          // a factor of exactly 1.0 passes a through
          if (b_q[FB]) begin
            res_q <= a_q;
          end else begin
            res_q <= prod_q[rmrst_pkg::SUM_W-1:0] + rmrst_pkg::SUM_W'(lo_q);
          end
          done_q <= 1'b1;
          ph_q   <= PH_IDLE;
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/rmrst_seq.sv @@
// Tree walker: stack-driven traversal over the node RAM with the shared scaling unit.
`timescale 1ns / 1ps
module rmrst_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmrst_pkg::seq_cmd_t cmd_i,
  output rmrst_pkg::seq_sts_t sts_o
);

  localparam int LW = rmrst_pkg::LEAF_W;
  localparam int AW = rmrst_pkg::NODE_AW;
  localparam int SW = rmrst_pkg::STK_W;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_RDX,
    ST_RD,
    ST_WT,
    ST_WS,
    ST_PX,
    ST_DESC,
    ST_RET,
    ST_FINL,
    ST_FINR,
    ST_DONE
  } st_e;

  st_e                           state_q;
  logic [AW-1:0]                 clr_q;
  rmrst_pkg::op_e                op_q;
  logic [LW-1:0]                 lo_q, hi_q;
  logic [rmrst_pkg::TAG_W-1:0]   f_q;
  logic [rmrst_pkg::ACC_W-1:0]   acc_q;
  logic [LW-1:0]                 a_q, b_q;
  logic [AW-1:0]                 x_q;
  logic [SW:0]                   sp_q;
  logic [LW-1:0]                 stk_a_q [rmrst_pkg::STK_DEPTH];
  logic [LW-1:0]                 stk_b_q [rmrst_pkg::STK_DEPTH];
  logic [AW-1:0]                 stk_x_q [rmrst_pkg::STK_DEPTH];
  logic [rmrst_pkg::STK_DEPTH-1:0] stk_r_q;
  logic [rmrst_pkg::TAG_W-1:0]   mulby_q;
  logic [rmrst_pkg::SUM_W-1:0]   wsum_q;
  logic [rmrst_pkg::TAG_W-1:0]   wtag_q;
  logic [AW-1:0]                 waddr_q;
  logic                          push_q;
  logic [rmrst_pkg::SUM_W-1:0]   sumx_q;
  logic [AW-1:0]                 finx_q;
  logic [rmrst_pkg::SUM_W-1:0]   sl_q;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  rmrst_pkg::node_t              ram_wdata, rd;
  logic                          mul_start, mul_done;
  logic [rmrst_pkg::SUM_W-1:0]   mul_a, mul_res;
  logic [rmrst_pkg::TAG_W-1:0]   mul_b;

  logic [LW:0]                   ab_sum, tab_sum;
  logic [LW-1:0]                 mid, t_mid, cnt;
  logic                          covered, build;
  logic [SW-1:0]                 top;
  logic [LW-1:0]                 t_a, t_b;
  logic [AW-1:0]                 t_x, x_l, x_r, tx_l, tx_r;
  logic                          t_r;

  rmrst_ram #(
    .WIDTH(rmrst_pkg::NODE_W),
    .DEPTH(rmrst_pkg::NODE_DEPTH)
  ) u_nodes (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rd)
  );

  rmrst_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  assign build   = (op_q == rmrst_pkg::OP_BUILD);
  assign ab_sum  = {1'b0, a_q} + {1'b0, b_q};
  assign mid     = ab_sum[LW:1];
  assign cnt     = b_q - a_q + LW'(1);
  assign covered = (a_q >= lo_q) && (b_q <= hi_q);
  assign x_l     = {x_q[AW-2:0], 1'b0};
  assign x_r     = {x_q[AW-2:0], 1'b1};

  assign top     = SW'(sp_q - (SW+1)'(1));
  assign t_a     = stk_a_q[top];
  assign t_b     = stk_b_q[top];
  assign t_x     = stk_x_q[top];
  assign t_r     = stk_r_q[top];
  assign tab_sum = {1'b0, t_a} + {1'b0, t_b};
  assign t_mid   = tab_sum[LW:1];
  assign tx_l    = {t_x[AW-2:0], 1'b0};
  assign tx_r    = {t_x[AW-2:0], 1'b1};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = x_q;
    ram_wdata = '0;
    ram_raddr = x_q;
    mul_start = 1'b0;
    mul_a     = rmrst_pkg::SUM_W'(rd.tag);
    mul_b     = mulby_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '{tag: rmrst_pkg::ONE_Q, sum: '0};
      end
      ST_VISIT: begin
        if (build) begin
          ram_we    = 1'b1;
          ram_wdata = '{tag: rmrst_pkg::ONE_Q, sum: {cnt, rmrst_pkg::FRAC_BITS'(0)}};
        end
      end
      ST_RDX: begin
        if (covered && op_q == rmrst_pkg::OP_SCALE) begin
          mul_start = 1'b1;
          mul_b     = f_q;
        end
        ram_raddr = x_l;
      end
      ST_RD: begin
        mul_start = 1'b1;
      end
      ST_WT: begin
        mul_start = mul_done;
        mul_a     = wsum_q;
      end
      ST_WS: begin
        ram_we    = mul_done;
        ram_waddr = waddr_q;
        ram_wdata = '{tag: wtag_q, sum: mul_res};
        ram_raddr = {waddr_q[AW-1:1], 1'b1};
      end
      ST_PX: begin
        ram_we    = 1'b1;
        ram_wdata = '{tag: rmrst_pkg::ONE_Q, sum: sumx_q};
      end
      ST_RET: begin
        ram_raddr = tx_l;
      end
      ST_FINL: begin
        ram_raddr = {finx_q[AW-2:0], 1'b1};
      end
      ST_FINR: begin
        ram_we    = 1'b1;
        ram_waddr = finx_q;
        ram_wdata = '{tag: rmrst_pkg::ONE_Q, sum: sl_q + rd.sum};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      sp_q    <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (&clr_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_i.start) begin
            op_q    <= cmd_i.op;
            lo_q    <= cmd_i.lo;
            hi_q    <= cmd_i.hi;
            f_q     <= cmd_i.factor;
            a_q     <= LW'(1);
            b_q     <= cmd_i.n;
            x_q     <= AW'(1);
            sp_q    <= '0;
            acc_q   <= '0;
            state_q <= ST_VISIT;
          end
        end
        ST_VISIT: begin
          if (build) begin
            if (a_q == b_q) begin
              state_q <= ST_RET;
            end else begin
              stk_a_q[sp_q[SW-1:0]] <= a_q;
              stk_b_q[sp_q[SW-1:0]] <= b_q;
              stk_x_q[sp_q[SW-1:0]] <= x_q;
              stk_r_q[sp_q[SW-1:0]] <= 1'b0;
              sp_q <= sp_q + (SW+1)'(1);
              b_q  <= mid;
              x_q  <= x_l;
            end
          end else begin
            state_q <= ST_RDX;
          end
        end
        ST_RDX: begin
          if (covered) begin
            if (op_q == rmrst_pkg::OP_SCALE) begin
              wsum_q  <= rd.sum;
              mulby_q <= f_q;
              waddr_q <= x_q;
              push_q  <= 1'b0;
              state_q <= ST_WT;
            end else begin
              acc_q   <= acc_q + rmrst_pkg::ACC_W'(rd.sum);
              state_q <= ST_RET;
            end
          end else if (rd.tag != rmrst_pkg::ONE_Q) begin
            // push the pending factor into both children
            mulby_q <= rd.tag;
            sumx_q  <= rd.sum;
            waddr_q <= x_l;
            push_q  <= 1'b1;
            state_q <= ST_RD;
          end else begin
            state_q <= ST_DESC;
          end
        end
        ST_RD: begin
          wsum_q  <= rd.sum;
          state_q <= ST_WT;
        end
        ST_WT: begin
          if (mul_done) begin
            wtag_q  <= mul_res[rmrst_pkg::TAG_W-1:0];
            state_q <= ST_WS;
          end
        end
        ST_WS: begin
          if (mul_done) begin
            if (!push_q) begin
              state_q <= ST_RET;
            end else if (!waddr_q[0]) begin
              waddr_q <= {waddr_q[AW-1:1], 1'b1};
              state_q <= ST_RD;
            end else begin
              state_q <= ST_PX;
            end
          end
        end
        ST_PX: begin
          state_q <= ST_DESC;
        end
        ST_DESC: begin
          stk_a_q[sp_q[SW-1:0]] <= a_q;
          stk_b_q[sp_q[SW-1:0]] <= b_q;
          stk_x_q[sp_q[SW-1:0]] <= x_q;
          sp_q <= sp_q + (SW+1)'(1);
          if (lo_q <= mid) begin
            stk_r_q[sp_q[SW-1:0]] <= 1'b0;
            b_q <= mid;
            x_q <= x_l;
          end else begin
            stk_r_q[sp_q[SW-1:0]] <= 1'b1;
            a_q <= mid + LW'(1);
            x_q <= x_r;
          end
          state_q <= ST_VISIT;
        end
        ST_RET: begin
          if (sp_q == '0) begin
            state_q <= ST_DONE;
          end else if (!t_r && (build || hi_q > t_mid)) begin
            stk_r_q[top] <= 1'b1;
            a_q     <= t_mid + LW'(1);
            b_q     <= t_b;
            x_q     <= tx_r;
            state_q <= ST_VISIT;
          end else begin
            sp_q <= sp_q - (SW+1)'(1);
            if (op_q == rmrst_pkg::OP_SCALE) begin
              finx_q  <= t_x;
              state_q <= ST_FINL;
            end
          end
        end
        ST_FINL: begin
          sl_q    <= rd.sum;
          state_q <= ST_FINR;
        end
        ST_FINR: begin
          state_q <= ST_RET;
        end
        ST_DONE: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign sts_o.ready = (state_q == ST_IDLE);
  assign sts_o.done  = (state_q == ST_DONE);
  assign sts_o.sum   = acc_q;

endmodule

@@ rtl/range_multiply_range_sum_tree.sv @@
// Top level: stream ports, leaf count register and result register around the tree walker.
//
//  channel   | dir | contents (low bit first)
//  s_axis    | in  | tdata: range_lo[10:0], range_hi[21:11], factor[54:22]; tuser: req_type
//  m_axis    | out | tdata: range_sum[41:0]; tuser: range_error
//  cfg_wr    | in  | leaf_count, written when cfg_wr_en_i is high
//
// After reset a clearing pass sets every node tag to 1.0; no request is taken meanwhile.
// Init visits all 2n-1 nodes. Multiply and query walk the tree from the root through the
// node RAM; each product takes a low-word and a high-word pass on the single 32x32
// multiplier, and a pending tag is pushed into both children on the way down.
// One request is in work at a time; a result waiting behind a stalled output transfer
// holds s_axis_tready low.
`timescale 1ns / 1ps
module range_multiply_range_sum_tree (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [55:0]                 s_axis_tdata,   // range_lo, range_hi, factor
  input  logic [1:0]                  s_axis_tuser,   // req_type
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata,   // range_sum
  output logic [0:0]                  m_axis_tuser,   // range_error
  input  logic                        cfg_wr_en_i,
  input  logic [rmrst_pkg::LEAF_W-1:0] cfg_wr_data_i
);

  localparam int LW = rmrst_pkg::LEAF_W;
  localparam int OW = rmrst_pkg::OUT_SUM_W;

  logic [LW-1:0]               leaf_count_q, n;
  logic                        busy_q, has_res_q, is_qry_q, pend_q;
  logic [OW-1:0]               res_sum_q, out_sum_q;
  logic                        res_err_q, out_valid_q, out_err_q;
  logic                        accept, range_ok;
  rmrst_pkg::req_e             req;
  logic [LW-1:0]               lo, hi;
  logic [rmrst_pkg::TAG_W-1:0] factor;
  rmrst_pkg::seq_cmd_t         cmd;
  rmrst_pkg::seq_sts_t         sts;
  logic [OW-1:0]               sat_sum;

  assign req    = rmrst_pkg::req_e'(s_axis_tuser);
  assign lo     = s_axis_tdata[10:0];
  assign hi     = s_axis_tdata[21:11];
  assign factor = s_axis_tdata[54:22];

  assign n = (leaf_count_q > LW'(rmrst_pkg::MAX_LEAVES)) ? LW'(rmrst_pkg::MAX_LEAVES)
                                                         : leaf_count_q;
  assign range_ok = (n != '0) && (lo != '0) && (lo <= hi) && (hi <= n);

  assign s_axis_tready = sts.ready && !busy_q && !pend_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd.lo     = lo;
    cmd.hi     = hi;
    cmd.n      = n;
    // clamp factors above 1.0
    cmd.factor = factor[rmrst_pkg::FRAC_BITS] ? rmrst_pkg::ONE_Q : factor;
    cmd.op     = rmrst_pkg::OP_QUERY;
    cmd.start  = 1'b0;
    case (req)
      rmrst_pkg::REQ_INIT: begin
        cmd.op    = rmrst_pkg::OP_BUILD;
        cmd.start = accept && (n != '0);
      end
      rmrst_pkg::REQ_MUL: begin
        cmd.op    = rmrst_pkg::OP_SCALE;
        cmd.start = accept && range_ok;
      end
      rmrst_pkg::REQ_QRY: begin
        cmd.start = accept && range_ok;
      end
      default: ;
    endcase
  end

  rmrst_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .sts_o (sts)
  );

  assign sat_sum = (|sts.sum[rmrst_pkg::ACC_W-1:OW]) ? '1 : sts.sum[OW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= LW'(rmrst_pkg::MAX_LEAVES);
      busy_q       <= 1'b0;
      has_res_q    <= 1'b0;
      is_qry_q     <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        leaf_count_q <= cfg_wr_data_i;
      end

      if (cmd.start) begin
        busy_q    <= 1'b1;
        has_res_q <= (req != rmrst_pkg::REQ_INIT);
        is_qry_q  <= (req == rmrst_pkg::REQ_QRY);
      end else if (accept && !range_ok &&
                   (req == rmrst_pkg::REQ_MUL || req == rmrst_pkg::REQ_QRY)) begin
        pend_q    <= 1'b1;
        res_sum_q <= '0;
        res_err_q <= 1'b1;
      end

      if (busy_q && sts.done) begin
        busy_q <= 1'b0;
        if (has_res_q) begin
          pend_q    <= 1'b1;
          res_sum_q <= is_qry_q ? sat_sum : '0;
          res_err_q <= 1'b0;
        end
      end

      // move the held result into the output register when it frees up
      if (pend_q && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
        out_sum_q   <= res_sum_q;
        out_err_q   <= res_err_q;
        pend_q      <= 1'b0;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_sum_q};
  assign m_axis_tuser  = out_err_q;

endmodule
